// ===== src/fixed_point_atan2_macros.svh =====
// Assertion macros used by the top level of the fixed-point atan2 block.
`ifndef FIXED_POINT_ATAN2_MACROS_SVH
`define FIXED_POINT_ATAN2_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define FPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fpa_pkg.sv =====
// Shared constants and types of the fixed-point atan2 block.
`default_nettype none
package fpa_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int REM_W = 35;
	localparam int DEN_W = 34;
	localparam int ANGLE_W = 19;
	localparam logic [63:0] K3_Q32 = 64'd843102080;
	localparam logic [63:0] K1_Q32 = 64'd4216369394;
	localparam logic [63:0] PI_Q32 = 64'd13493037704;
	localparam logic signed [63:0] ANGLE_MAX = 64'sd262143;
	localparam logic signed [63:0] ANGLE_MIN = -64'sd262144;

	typedef struct packed {
		logic origin;
		logic y_neg;
		logic x_neg;
		logic r_neg;
	} fpa_flags_t;
endpackage
`default_nettype wire

// ===== src/fpa_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per item.
`default_nettype none
module fpa_div_cell #(
	parameter int QW = fpa_pkg::FRAC_BITS_DEF + 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [fpa_pkg::REM_W-1:0]    in_rem,
	input  wire logic [fpa_pkg::DEN_W-1:0]    in_den,
	input  wire logic [QW-1:0]                in_q,
	input  wire fpa_pkg::fpa_flags_t          in_flags,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [fpa_pkg::REM_W-1:0]         out_rem,
	output logic [fpa_pkg::DEN_W-1:0]         out_den,
	output logic [QW-1:0]                     out_q,
	output fpa_pkg::fpa_flags_t               out_flags
);
	logic                          valid_q;
	logic [fpa_pkg::REM_W-1:0]     rem_q;
	logic [fpa_pkg::DEN_W-1:0]     den_q;
	logic [QW-1:0]                 q_q;
	fpa_pkg::fpa_flags_t           flags_q;
	logic                          ge;
	logic [fpa_pkg::REM_W-1:0]     den_ext;
	logic [fpa_pkg::REM_W-1:0]     diff;

	assign in_ready = !valid_q || out_ready;
	assign den_ext = {1'b0, in_den};
	assign ge = in_rem >= den_ext;
	assign diff = ge ? (in_rem - den_ext) : in_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q <= {diff[fpa_pkg::REM_W-2:0], 1'b0};
			den_q <= in_den;
			q_q <= {in_q[QW-2:0], ge};
			flags_q <= in_flags;
		end
	end

	assign out_valid = valid_q;
	assign out_rem = rem_q;
	assign out_den = den_q;
	assign out_q = q_q;
	assign out_flags = flags_q;
endmodule
`default_nettype wire

// ===== src/fpa_poly.sv =====
// Cubic polynomial, sign handling and saturation after the divider.
`default_nettype none
module fpa_poly #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [FRAC_BITS:0]            in_q,
	input  wire fpa_pkg::fpa_flags_t           in_flags,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fpa_pkg::ANGLE_W-1:0]        out_angle
);
	localparam int RW = FRAC_BITS + 2;
	localparam int PW = 2 * RW;
	localparam int AW = FRAC_BITS + 4;
	localparam logic [63:0] K3_L = fpa_pkg::K3_Q32 >> (32 - FRAC_BITS);
	localparam logic [63:0] K1_L = fpa_pkg::K1_Q32 >> (32 - FRAC_BITS);
	localparam logic [63:0] QTR_L = (fpa_pkg::PI_Q32 >> (32 - FRAC_BITS)) / 4;
	localparam logic signed [RW-1:0] K3_S = RW'(K3_L);
	localparam logic signed [RW-1:0] K1_S = RW'(K1_L);
	localparam logic signed [AW-1:0] QTR_S = AW'(QTR_L);
	localparam logic signed [AW-1:0] QTR3_S = AW'(3 * QTR_L);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic signed [RW-1:0] r_s1, r2_s1, t1_s1;
	logic signed [RW-1:0] r3_s2, t1_s2;
	logic signed [RW-1:0] t3_s3, t1_s3;
	fpa_pkg::fpa_flags_t fl_s1, fl_s2, fl_s3;
	logic [fpa_pkg::ANGLE_W-1:0] angle_s4;

	logic signed [RW-1:0] r_in;
	logic signed [PW-1:0] p_rr, p_k1, p_r3, p_k3;
	logic signed [PW-1:0] b_k1, b_r3, b_k3;
	logic signed [PW-1:0] bias;
	logic signed [AW-1:0] sum, base, sgn;
	logic signed [63:0] a64;
	logic signed [63:0] sat;

	assign bias = PW'({FRAC_BITS{1'b1}});
	assign r_in = in_flags.r_neg ? -signed'({1'b0, in_q}) : signed'({1'b0, in_q});
	assign p_rr = r_in * r_in;
	assign p_k1 = K1_S * r_in;
	assign b_k1 = p_k1 + (p_k1[PW-1] ? bias : '0);
	assign p_r3 = r2_s1 * r_s1;
	assign b_r3 = p_r3 + (p_r3[PW-1] ? bias : '0);
	assign p_k3 = K3_S * r3_s2;
	assign b_k3 = p_k3 + (p_k3[PW-1] ? bias : '0);

	assign base = fl_s3.x_neg ? QTR3_S : QTR_S;
	assign sum = {{2{t3_s3[RW-1]}}, t3_s3} - {{2{t1_s3[RW-1]}}, t1_s3} + base;
	assign sgn = fl_s3.y_neg ? -sum : sum;
	assign a64 = {{(64 - AW){sgn[AW-1]}}, sgn};
	always_comb begin
		if (fl_s3.origin) begin
			sat = '0;
		end else if (a64 > fpa_pkg::ANGLE_MAX) begin
			sat = fpa_pkg::ANGLE_MAX;
		end else if (a64 < fpa_pkg::ANGLE_MIN) begin
			sat = fpa_pkg::ANGLE_MIN;
		end else begin
			sat = a64;
		end
	end

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			r_s1 <= r_in;
			r2_s1 <= RW'(p_rr >>> FRAC_BITS);
			t1_s1 <= RW'(b_k1 >>> FRAC_BITS);
			fl_s1 <= in_flags;
		end
		if (rdy2 && v_s1) begin
			r3_s2 <= RW'(b_r3 >>> FRAC_BITS);
			t1_s2 <= t1_s1;
			fl_s2 <= fl_s1;
		end
		if (rdy3 && v_s2) begin
			t3_s3 <= RW'(b_k3 >>> FRAC_BITS);
			t1_s3 <= t1_s2;
			fl_s3 <= fl_s2;
		end
		if (rdy4 && v_s3) begin
			angle_s4 <= sat[fpa_pkg::ANGLE_W-1:0];
		end
	end

	assign out_valid = v_s4;
	assign out_angle = angle_s4;
endmodule
`default_nettype wire

// ===== src/fixed_point_atan2.sv =====
// Top level of the fixed-point atan2 block: front end, divider chain, polynomial.
// Each item passes the front-end register, the division cells and the polynomial stages in turn.
// One item is accepted per cycle unless the pipe stalls; each stage stalls only when it is full and
// the stage after it cannot take its item, so bubbles close up under backpressure.
// The latency is set mostly by the divider, one cell per quotient bit in a chain.
// arst_n clears all valid flags at once; data registers are not reset.
`default_nettype none
module fixed_point_atan2 #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] coord_y, [63:32] coord_x
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // [18:0] angle, [23:19] zero
);
	`include "fixed_point_atan2_macros.svh"

	// The quotient magnitude never exceeds one, so FRAC_BITS + 1 bits hold it,
	// one bit per division cell.
	localparam int QW = FRAC_BITS + 1;
	localparam int NC = QW;

	// Front end: fold the point into a numerator and a non-negative divisor.
	logic signed [31:0] y_in, x_in;
	logic signed [33:0] y34, x34, ay34, num, den;
	logic [33:0] num_mag;
	fpa_pkg::fpa_flags_t flags_in;

	assign y_in = s_tdata[31:0];
	assign x_in = s_tdata[63:32];
	assign y34 = {{2{y_in[31]}}, y_in};
	assign x34 = {{2{x_in[31]}}, x_in};
	assign ay34 = y_in[31] ? -y34 : y34;
	assign num = x_in[31] ? (x34 + ay34) : (x34 - ay34);
	assign den = x_in[31] ? (ay34 - x34) : (x34 + ay34);
	assign num_mag = num[33] ? 34'(-num) : 34'(num);
	always_comb begin
		flags_in.origin = (y_in == 32'sd0) && (x_in == 32'sd0);
		flags_in.y_neg = y_in[31];
		flags_in.x_neg = x_in[31];
		flags_in.r_neg = num[33];
	end

	logic                          valid_s1;
	logic [fpa_pkg::REM_W-1:0]     rem_s1;
	logic [fpa_pkg::DEN_W-1:0]     den_s1;
	fpa_pkg::fpa_flags_t           flags_s1;

	// Division chain wiring; slot zero is fed by the front-end register.
	logic [NC:0]                         c_valid;
	logic [NC:0]                         c_ready;
	logic [NC:0][fpa_pkg::REM_W-1:0]     c_rem;
	logic [NC:0][fpa_pkg::DEN_W-1:0]     c_den;
	logic [NC:0][QW-1:0]                 c_q;
	fpa_pkg::fpa_flags_t [NC:0]          c_flags;

	assign s_tready = !valid_s1 || c_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rem_s1 <= {1'b0, num_mag};
			den_s1 <= den;
			flags_s1 <= flags_in;
		end
	end

	assign c_valid[0] = valid_s1;
	assign c_rem[0] = rem_s1;
	assign c_den[0] = den_s1;
	assign c_q[0] = '0;
	assign c_flags[0] = flags_s1;

	// Each cell resolves one quotient bit, most significant first.
	for (genvar i = 0; i < NC; i++) begin : g_cell
		fpa_div_cell #(.QW(QW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_rem    (c_rem[i]),
			.in_den    (c_den[i]),
			.in_q      (c_q[i]),
			.in_flags  (c_flags[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_rem   (c_rem[i+1]),
			.out_den   (c_den[i+1]),
			.out_q     (c_q[i+1]),
			.out_flags (c_flags[i+1])
		);
	end

	// The final remainder and divisor are not needed past the chain; the
	// polynomial takes the quotient and flags.
	logic [fpa_pkg::ANGLE_W-1:0] angle;

	fpa_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid[NC]),
		.in_ready  (c_ready[NC]),
		.in_q      (c_q[NC]),
		.in_flags  (c_flags[NC]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_angle (angle)
	);

	assign m_tdata = {5'd0, angle};

	// An accepted item always lands in the front-end register.
	`FPA_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, valid_s1, "accepted item lost")
	// Input stalls only when the whole pipe is full and the output is blocked.
	`FPA_ASSERT_NOW(a_stall_full, !s_tready, m_tvalid && !m_tready, "stall with a bubble")
	// The divisor is zero exactly for the origin.
	`FPA_ASSERT_NOW(a_origin_den, valid_s1, flags_s1.origin == (den_s1 == '0), "origin flag")
endmodule
`default_nettype wire

// ===== test/atan2_checker.sv =====
// Checker for the fixed-point atan2 block: predicts each angle and compares it, and checks the pad bits are zero.
module atan2_checker #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] coord_y, [63:32] coord_x
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [18:0] angle, [23:19] zero
	output int          errors,
	output int          outstanding,
	output int          n_results
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [fpa_pkg::ANGLE_W-1:0] angle_queue[$];

	function automatic longint fx_product(longint a, longint b);
		return (a * b) / (longint'(1) <<< FRAC_BITS);
	endfunction

	// Cubic approximation of atan2, with every product truncated toward zero.
	function automatic logic [fpa_pkg::ANGLE_W-1:0] predict_angle(
		logic signed [31:0] y, logic signed [31:0] x);
		longint sy, sx, ay, k3, k1, quarter, ratio, base, ang;
		sy = y;
		sx = x;
		ay = (sy < 0) ? -sy : sy;
		k3 = longint'(fpa_pkg::K3_Q32 >> (32 - FRAC_BITS));
		k1 = longint'(fpa_pkg::K1_Q32 >> (32 - FRAC_BITS));
		quarter = longint'(fpa_pkg::PI_Q32 >> (32 - FRAC_BITS)) / 4;
		if (sy == 0 && sx == 0)
			return '0;
		if (sx >= 0) begin
			ratio = ((sx - ay) * (longint'(1) <<< FRAC_BITS)) / (sx + ay);
			base = quarter;
		end else begin
			ratio = ((sx + ay) * (longint'(1) <<< FRAC_BITS)) / (ay - sx);
			base = 3 * quarter;
		end
		ang = fx_product(k3, fx_product(fx_product(ratio, ratio), ratio))
			- fx_product(k1, ratio) + base;
		if (sy < 0)
			ang = -ang;
		if (ang > fpa_pkg::ANGLE_MAX)
			ang = fpa_pkg::ANGLE_MAX;
		if (ang < fpa_pkg::ANGLE_MIN)
			ang = fpa_pkg::ANGLE_MIN;
		return ang[fpa_pkg::ANGLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [fpa_pkg::ANGLE_W-1:0] want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			angle_queue.delete();
			errors <= 0;
			outstanding <= 0;
			n_results <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results <= n_results + 1;
				if (angle_queue.size() == 0) begin
					$display("%0t: result %h arrived with nothing expected", $time, m_tdata);
					bad++;
				end else begin
					want = angle_queue.pop_front();
					if (m_tdata[fpa_pkg::ANGLE_W-1:0] !== want) begin
						$display("%0t: angle expected %h, got %h", $time, want,
							m_tdata[fpa_pkg::ANGLE_W-1:0]);
						bad++;
					end
					if (m_tdata[23:fpa_pkg::ANGLE_W] !== '0) begin
						$display("%0t: pad bits expected 0, got %h", $time,
							m_tdata[23:fpa_pkg::ANGLE_W]);
						bad++;
					end
				end
			end
			errors <= errors + bad;
			if (s_tvalid && s_tready)
				angle_queue.push_back(predict_angle(s_tdata[31:0], s_tdata[63:32]));
			outstanding <= angle_queue.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
// Testbench top of the fixed-point atan2 block: stimulus, flow control and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1930;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // [31:0] coord_y, [63:32] coord_x
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [18:0] angle, [23:19] zero
	int          errors, outstanding, n_results;
	int          cycles = 0;
	int          sent = 0;
	int          burst_left = 0;
	logic        hold_request = 1'b0;

	always #5 clk = ~clk;

	fixed_point_atan2 DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	atan2_checker CHECK (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .outstanding(outstanding), .n_results(n_results)
	);

	// The run is cut off at a generous cycle count in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// The receiver switches between stretches of constant readiness and random
	// stalls. A hold request from the stimulus side holds it off for a long
	// stretch so that the pipeline fills and pushes back on the sender.
	initial begin
		int phase_left, mode, hold_count;
		phase_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				for (hold_count = 0; hold_count < LONG_HOLD; hold_count++)
					@(negedge clk);
				hold_request = 1'b0;
			end
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(5, 60);
			end
			phase_left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 1) != 0);
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// Offers one item and waits until it is taken. The sender runs in bursts
	// of random length, with idle gaps, sometimes none, between them; valid stays high across
	// a burst.
	task automatic offer_point(logic [31:0] y, logic [31:0] x);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {x, y};
		do @(posedge clk); while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	// Random coordinates: full scale, small magnitudes, and points near an axis
	// or on a diagonal, where the ratio sits at its ends or at zero.
	function automatic logic [63:0] random_point();
		logic [31:0] y, x;
		y = $urandom();
		x = $urandom();
		case ($urandom_range(0, 5))
			0, 1: ;
			2: begin
				y = {{16{y[15]}}, y[15:0]};
				x = {{16{x[15]}}, x[15:0]};
			end
			3: y = $urandom_range(0, 1) ? 32'(-$signed(x)) : x;
			4: y = $urandom_range(0, 1) ? '0 : {{28{y[3]}}, y[3:0]};
			default: x = $urandom_range(0, 1) ? '0 : {{28{x[3]}}, x[3:0]};
		endcase
		return {x, y};
	endfunction

	initial begin
		logic [63:0] point;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed points: the origin, both axes, full-scale corners, the
		// diagonals where x equals plus or minus |y|, and points just off the x axis.
		offer_point(32'sd0, 32'sd0);
		offer_point(32'sd0, 32'sd65536);
		offer_point(32'sd0, -32'sd65536);
		offer_point(32'sd65536, 32'sd0);
		offer_point(-32'sd65536, 32'sd0);
		offer_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		offer_point(32'h8000_0000, 32'h8000_0000);
		offer_point(32'h8000_0000, 32'h7FFF_FFFF);
		offer_point(32'h7FFF_FFFF, 32'h8000_0000);
		offer_point(32'h8000_0000, 32'sd0);
		offer_point(32'sd0, 32'h8000_0000);
		offer_point(32'h7FFF_FFFF, 32'sd0);
		offer_point(32'sd0, 32'h7FFF_FFFF);
		offer_point(32'sd1, -32'sd1);
		offer_point(-32'sd1, 32'sd1);
		offer_point(32'sd1, 32'sd1);
		offer_point(-32'sd1, -32'sd1);
		offer_point(32'sd0, 32'sd1);
		offer_point(32'sd0, -32'sd1);
		offer_point(32'sd1, 32'h7FFF_FFFF);
		offer_point(-32'sd1, 32'h8000_0000);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Once the receiver is held off so the block backs up, and once
			// the sender waits for the pipeline to drain completely.
			if (i == RANDOM_ITEMS / 3)
				hold_request = 1'b1;
			if (i == 2 * RANDOM_ITEMS / 3) begin
				s_tvalid <= 1'b0;
				burst_left = 0;
				while (outstanding != 0) @(negedge clk);
			end
			point = random_point();
			offer_point(point[31:0], point[63:32]);
		end
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("sent %0d points, checked %0d angles, including axes, corners,",
			sent, n_results);
		$display("diagonals, the origin, a long output stall and a full drain");
		if (errors == 0 && outstanding == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule

// ===== fixed_point_atan2.f =====
+incdir+src
src/fpa_pkg.sv
src/fpa_div_cell.sv
src/fpa_poly.sv
src/fixed_point_atan2.sv
test/atan2_checker.sv
test/tb_top.sv
